/* hdl/utf8s_pkg.sv */
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types, constants and helpers for the UTF-8 sanitiser core.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    // replacement character '?'
    localparam logic [7:0] QMARK = 8'h3F;

    // result queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;
    // most results one input byte can cause
    localparam int MAX_RES    = 4;

    // one result request as it sits in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       replaced;
        logic       run_last;
        logic       stream_end;
    } result_t;

    // decoder verdict for one byte
    typedef struct packed {
        logic [2:0]              n;
        result_t [MAX_RES-1:0]   res;
        logic [1:0]              count_next;
        logic                    hold_lead;
        logic                    hold_cont;
    } decode_t;

    // number of continuation bytes a lead byte asks for
    function automatic logic [1:0] cont_needed(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b >= 8'hC0 && b <= 8'hDF)
        begin
            n = 2'd1;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            n = 2'd2;
        end
        else if (b >= 8'hF0 && b <= 8'hF7)
        begin
            n = 2'd3;
        end
        return n;
    endfunction

endpackage

/* hdl/utf8s_decode.sv */
// ----------------------------------------------------------------------------
// utf8s_decode
// Single-pass classification of one byte against the held sequence; gives
// the list of result requests and the next held state.
// ----------------------------------------------------------------------------
module utf8s_decode
(
    input  logic [1:0]        held_count,
    input  logic [2:0][7:0]   held,
    input  logic [7:0]        byte_in,
    input  logic              last,
    output utf8s_pkg::decode_t dec
);
    import utf8s_pkg::*;

    logic [1:0]       need;
    logic             is_cont;
    logic             broken;
    logic             pass_case;
    logic             fail_cont;
    logic             hold_cont;
    logic             hold_lead;
    logic             prefix_rep;
    logic [2:0]       prefix_len;
    logic [7:0]       tail_byte;
    logic             tail_rep;
    logic             tail_valid;
    logic [2:0]       n;
    logic [3:0][7:0]  pre;

    // classify the byte against the open sequence
    always_comb
    begin
        need      = cont_needed(held[0]);
        is_cont   = (byte_in[7:6] == 2'b10);
        broken    = (held_count != 2'd0) && ((need == 2'd0) || (held_count > need));
        pass_case = 1'b0;
        fail_cont = 1'b0;
        hold_cont = 1'b0;
        if (held_count != 2'd0 && !broken && is_cont)
        begin
            if (held_count == need)
            begin
                pass_case = 1'b1;
            end
            else if (last)
            begin
                fail_cont = 1'b1;
            end
            else
            begin
                hold_cont = 1'b1;
            end
        end
    end

    // tail result: the new byte itself, a '?', or nothing when held
    always_comb
    begin
        hold_lead  = 1'b0;
        tail_byte  = QMARK;
        tail_rep   = 1'b1;
        tail_valid = 1'b1;
        if (pass_case)
        begin
            tail_byte = byte_in;
            tail_rep  = 1'b0;
        end
        else if (hold_cont)
        begin
            tail_valid = 1'b0;
        end
        else if (!fail_cont)
        begin
            // byte taken as a new lead
            if (byte_in[7] == 1'b0)
            begin
                tail_byte = byte_in;
                tail_rep  = 1'b0;
            end
            else if (cont_needed(byte_in) != 2'd0 && !last)
            begin
                hold_lead  = 1'b1;
                tail_valid = 1'b0;
            end
        end
    end

    // build the result list: held prefix then tail
    always_comb
    begin
        pre        = {8'h00, held[2], held[1], held[0]};
        prefix_rep = !pass_case;
        prefix_len = hold_cont ? 3'd0 : {1'b0, held_count};
        n          = prefix_len + {2'b00, tail_valid};
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (3'(i) < prefix_len)
            begin
                dec.res[i].data     = prefix_rep ? QMARK : pre[i];
                dec.res[i].replaced = prefix_rep;
            end
            else
            begin
                dec.res[i].data     = tail_byte;
                dec.res[i].replaced = tail_rep;
            end
            dec.res[i].run_last   = (3'(i) + 3'd1 == n);
            dec.res[i].stream_end = (3'(i) + 3'd1 == n) && last;
        end
        dec.n         = n;
        dec.hold_lead = hold_lead;
        dec.hold_cont = hold_cont;
        if (hold_cont)
        begin
            dec.count_next = held_count + 2'd1;
        end
        else if (hold_lead)
        begin
            dec.count_next = 2'd1;
        end
        else
        begin
            dec.count_next = 2'd0;
        end
    end

endmodule

/* hdl/utf8_sanitizer_core.sv */
// ----------------------------------------------------------------------------
// utf8_sanitizer_core
// Streaming UTF-8 shape check with '?' replacement of broken sequences.
// ----------------------------------------------------------------------------
// The core takes one byte per cycle unless its input stalls. A byte is
// registered in the input stage, checked against the held sequence, and its
// results (0 to 4) are written into an 8-entry result queue, whose head is
// presented on the output. Results leave one per cycle while the output side
// is ready; the queue absorbs the burst of a byte that completes or breaks a
// sequence of four, and input stalls only while more than four results are
// queued. No result is ever produced for more bytes than came in, so a steady
// one-byte-per-cycle stream runs without stalls when the output side is always
// ready.
module utf8_sanitizer_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       was_replaced,
    output logic       run_last,
    output logic       stream_end
);
    import utf8s_pkg::*;

    logic                stage_valid_reg;
    logic [7:0]          stage_byte_reg;
    logic                stage_last_reg;
    logic [1:0]          held_count_reg;
    logic [2:0][7:0]     held_reg;
    result_t             fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    decode_t             dec;
    logic                fire;
    logic                pop;
    logic                in_take;
    result_t             head;

    // a byte is processed when the queue has room for the worst case
    assign fire     = stage_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RES));
    assign in_ready = !stage_valid_reg || fire;
    assign in_take  = in_valid && in_ready;
    assign pop      = out_valid && out_ready;

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_byte_reg <= in_byte;
            stage_last_reg <= in_last;
        end
    end

    utf8s_decode u_decode
    (
        .held_count (held_count_reg),
        .held       (held_reg),
        .byte_in    (stage_byte_reg),
        .last       (stage_last_reg),
        .dec        (dec)
    );

    // held sequence count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
        end
        else if (fire)
        begin
            held_count_reg <= dec.count_next;
        end
    end

    // held sequence bytes
    always_ff @(posedge clk)
    begin
        if (fire && dec.hold_lead)
        begin
            held_reg[0] <= stage_byte_reg;
        end
        else if (fire && dec.hold_cont)
        begin
            held_reg[held_count_reg] <= stage_byte_reg;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (fire && (3'(i) < dec.n))
            begin
                fifo_reg[wr_ptr_reg + PTR_W'(i)] <= dec.res[i];
            end
        end
    end

    // result queue pointers
    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            count_next = count_next + CNT_W'(dec.n);
        end
        if (pop)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(dec.n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // output request
    assign head         = fifo_reg[rd_ptr_reg];
    assign out_valid    = (count_reg != '0);
    assign out_byte     = head.data;
    assign was_replaced = head.replaced;
    assign run_last     = head.run_last;
    assign stream_end   = head.stream_end;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // end of stream leaves no held bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage_last_reg |=> held_count_reg == 2'd0)
        else $error("held bytes survive end of stream");

    // a final byte always yields at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage_last_reg |-> dec.n != 3'd0)
        else $error("end of stream without result");

    // a byte that is held with nothing to flush produces no result
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (dec.hold_cont || (dec.hold_lead && held_count_reg == 2'd0))
            |-> dec.n == 3'd0)
        else $error("held byte produced a result");

endmodule

/* tb/sv/utf8_sanitizer_checker.sv */
// ----------------------------------------------------------------------------
// utf8_sanitizer_checker
// Watches both channels of the UTF-8 sanitiser core, keeps its own model of
// the open sequence, queues the output requests each accepted byte should
// cause and compares every accepted output request field by field.
// ----------------------------------------------------------------------------
module utf8_sanitizer_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       was_replaced,
    input  logic       run_last,
    input  logic       stream_end,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import utf8s_pkg::*;

    // open sequence: lead byte and continuations seen so far
    logic [7:0] seq_bytes [0:2];
    logic [1:0] seq_count;

    // output requests of the current byte, and all still awaited
    result_t    step_res [$];
    result_t    awaited_res [$];
    int         errs;

    // continuation bytes a lead asks for
    function automatic logic [1:0] trail_count(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b >= 8'hF0 && b <= 8'hF7)
        begin
            n = 2'd3;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            n = 2'd2;
        end
        else if (b >= 8'hC0 && b <= 8'hDF)
        begin
            n = 2'd1;
        end
        return n;
    endfunction

    function automatic result_t make_res(input logic [7:0] b, input logic rep);
        result_t r;
        r.data       = b;
        r.replaced   = rep;
        r.run_last   = 1'b0;
        r.stream_end = 1'b0;
        return r;
    endfunction

    // append one output request to the current byte's list
    task automatic add_res(input result_t r);
        step_res = {step_res, r};
    endtask

    // byte seen with nothing open
    task automatic start_seq(input logic [7:0] b, input logic last);
        if (b[7] == 1'b0)
        begin
            add_res(make_res(b, 1'b0));
        end
        else if (trail_count(b) != 2'd0 && !last)
        begin
            seq_bytes[0] = b;
            seq_count    = 2'd1;
        end
        else
        begin
            add_res(make_res(QMARK, 1'b1));
        end
    endtask

    // broken sequence: every held byte turns into a replacement
    task automatic drop_seq;
        for (int i = 0; i < seq_count; i++)
        begin
            add_res(make_res(QMARK, 1'b1));
        end
        seq_count = 2'd0;
    endtask

    // work out the output requests caused by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic last);
        step_res.delete();
        if (seq_count == 2'd0)
        begin
            start_seq(b, last);
        end
        else if (b[7:6] == 2'b10)
        begin
            if (seq_count == trail_count(seq_bytes[0]))
            begin
                for (int i = 0; i < seq_count; i++)
                begin
                    add_res(make_res(seq_bytes[i], 1'b0));
                end
                add_res(make_res(b, 1'b0));
                seq_count = 2'd0;
            end
            else if (last)
            begin
                drop_seq();
                add_res(make_res(QMARK, 1'b1));
            end
            else
            begin
                seq_bytes[seq_count] = b;
                seq_count = seq_count + 2'd1;
            end
        end
        else
        begin
            drop_seq();
            start_seq(b, last);
        end
        // mark the tail of this byte's run
        if (step_res.size() > 0)
        begin
            step_res[step_res.size() - 1].run_last   = 1'b1;
            step_res[step_res.size() - 1].stream_end = last;
        end
        awaited_res = {awaited_res, step_res};
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errs++;
        end
    endtask

    // sample both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n)
        begin
            seq_count = 2'd0;
            awaited_res.delete();
            errs = 0;
        end
        else
        begin
            // output request against the oldest awaited one
            if (out_valid && out_ready)
            begin
                if (awaited_res.size() == 0)
                begin
                    $error("unexpected output request: out_byte %0h", out_byte);
                    errs++;
                end
                else
                begin
                    w = awaited_res.pop_front();
                    check_field("out_byte", w.data, out_byte);
                    check_field("was_replaced", {7'd0, w.replaced}, {7'd0, was_replaced});
                    check_field("run_last", {7'd0, w.run_last}, {7'd0, run_last});
                    check_field("stream_end", {7'd0, w.stream_end}, {7'd0, stream_end});
                end
            end
            // input request
            if (in_valid && in_ready)
            begin
                predict_byte(in_byte, in_last);
            end
        end
        fail_count <= errs;
        pending    <= awaited_res.size();
    end

endmodule

/* tb/sv/utf8_sanitizer_core_tb.sv */
// ----------------------------------------------------------------------------
// utf8_sanitizer_core_tb
// Drives the UTF-8 sanitiser core with a directed set of edge cases and then
// random streams, mostly well-shaped sequences with broken ones and noise
// mixed in, under random gaps and stalls on both sides; a checker beside the
// core predicts and compares every output request.
// ----------------------------------------------------------------------------
module utf8_sanitizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 195;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 200;
    localparam int N_DIRECTED   = 25;

    // bit 8 is in_last, bits 7:0 the byte
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h000, 9'h07F,                 // ascii extremes
        9'h0C3, 9'h0A9,                 // two-byte sequence
        9'h0E2, 9'h082, 9'h0AC,         // three-byte sequence
        9'h0F0, 9'h09F, 9'h098, 9'h080, // four-byte sequence
        9'h080, 9'h0BF,                 // stray continuations
        9'h0F8, 9'h0FF,                 // never-valid leads
        9'h0E0, 9'h041,                 // sequence broken by ascii
        9'h0F7, 9'h090, 9'h080, 9'h0DF, // sequence broken by a new lead
        9'h0BF,                         // completes the new lead
        9'h0EF, 9'h182,                 // stream ends mid-sequence
        9'h1C0                          // lead on the final byte
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;
    logic       stream_end;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int cycle_count = 0;
    bit idle_in = 1'b1;
    bit idle_out = 1'b1;
    bit hold_off_req = 1'b0;

    utf8_sanitizer_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .was_replaced (was_replaced),
        .run_last     (run_last),
        .stream_end   (stream_end)
    );

    utf8_sanitizer_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .was_replaced (was_replaced),
        .run_last     (run_last),
        .stream_end   (stream_end),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one input request and wait until it is taken
    task automatic offer_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_in ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    function automatic logic pick_last();
        return ($urandom_range(0, 29) == 0);
    endfunction

    function automatic logic [7:0] pick_lead(input int len);
        logic [7:0] b;
        case (len)
            1:       b = 8'($urandom_range(8'hC0, 8'hDF));
            2:       b = 8'($urandom_range(8'hE0, 8'hEF));
            default: b = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_cont();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // one random unit: ascii, a whole sequence, a truncated one, or noise
    task automatic offer_random_unit;
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            offer_byte(8'($urandom_range(0, 127)), pick_last());
        end
        else if (kind < 80)
        begin
            len = $urandom_range(1, 3);
            offer_byte(pick_lead(len), pick_last());
            repeat (len) offer_byte(pick_cont(), pick_last());
        end
        else if (kind < 90)
        begin
            len = $urandom_range(2, 3);
            offer_byte(pick_lead(len), pick_last());
            repeat ($urandom_range(0, len - 1)) offer_byte(pick_cont(), pick_last());
            offer_byte(8'($urandom), pick_last());
        end
        else
        begin
            offer_byte(8'($urandom), pick_last());
        end
    endtask

    // sender goes quiet until every awaited request has come out
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = idle_out ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int rand_start;
        int phase;
        int prev_phase;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edge cases
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            offer_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        end

        // random streams in phases of differing pressure
        rand_start = bytes_sent;
        prev_phase = -1;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            phase = (bytes_sent - rand_start) / 45;
            if (phase != prev_phase)
            begin
                prev_phase = phase;
                case (phase)
                    0:
                    begin
                        idle_in  = 1'b1;
                        idle_out = 1'b1;
                    end
                    1:
                    begin
                        // no gaps, and the output side holds off so the core fills
                        idle_in      = 1'b0;
                        idle_out     = 1'b0;
                        hold_off_req = 1'b1;
                    end
                    2:
                    begin
                        idle_in  = 1'b1;
                        idle_out = 1'b0;
                    end
                    3:
                    begin
                        idle_in  = 1'b0;
                        idle_out = 1'b1;
                    end
                    default:
                    begin
                        // sender pauses until the core has drained
                        wait_drained();
                        idle_in  = 1'b1;
                        idle_out = 1'b1;
                    end
                endcase
            end
            offer_random_unit();
        end

        // drain and settle
        wait_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/utf8s_pkg.sv
hdl/utf8s_decode.sv
hdl/utf8_sanitizer_core.sv
tb/sv/utf8_sanitizer_checker.sv
tb/sv/utf8_sanitizer_core_tb.sv
